// ===== rtl/bole_pkg.sv =====
// shared types and constants for the bounded ordered list engine
package bole_pkg;

  // store size and derived widths
  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int FILL_W   = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE    = 2'd2;
  localparam logic [FUNC_W-1:0] FN_SEARCH    = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic                      shift_in;  // insert at front, row moves one cell back
    logic                      append;    // insert at back, first free cell takes key
    logic                      remove;    // delete, cells from the match on pull forward
    logic signed [VALUE_W-1:0] key;       // value of the current word
  } cell_ctl_t;

endpackage

// ===== rtl/bole_cell.sv =====
// one storage cell of the list row: holds an entry, compares it and moves it
module bole_cell
  import bole_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cell_ctl_t                 ctl,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic                      left_used,
  input  logic signed [VALUE_W-1:0] right_value,
  input  logic                      right_used,
  input  logic                      prefix_in,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      used_o,
  output logic                      prefix_out
);

  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic                      used_r, used_nxt;
  logic                      match;

  // compare against the key and extend the found-so-far chain
  assign match      = used_r && (value_r == ctl.key);
  assign prefix_out = prefix_in || match;

  // next entry for this cell
  always_comb begin
    value_nxt = value_r;
    used_nxt  = used_r;
    if (ctl.shift_in) begin
      value_nxt = left_value;
      used_nxt  = left_used;
    end else if (ctl.append) begin
      if (!used_r && left_used) begin
        value_nxt = ctl.key;
      end
      used_nxt = used_r || left_used;
    end else if (ctl.remove) begin
      if (prefix_in || match) begin
        value_nxt = right_value;
        used_nxt  = right_used;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // stored value, no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;
  assign used_o  = used_r;

endmodule

// ===== rtl/bounded_ordered_list_engine_top.sv =====
// top level of the bounded ordered list engine: cell row, control and result register
//
// The list lives in a row of CAPACITY cells, front at cell 0, occupied cells
// always packed at the front. Every operation (insert front, insert back,
// delete first match, search) finishes in the cycle its word is accepted: all
// cells compare the key at once, a found-so-far bit ripples down the row, and
// each cell loads from its left or right neighbor as needed. The result is
// registered in an output register, and a new word is taken whenever that
// register is empty or being drained, so the block sustains one word per cycle
// with out_ready held high. The ripple of the found-so-far bit through all
// cells is the long path.
module bounded_ordered_list_engine_top
  import bole_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_hit,
  output logic [COUNT_W-1:0]         out_count_after
);

  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]       cell_used;
  logic [CAPACITY:0]         prefix;
  cell_ctl_t                 ctl;

  logic                      accept;
  logic                      full;
  logic                      found;
  logic [STATUS_W-1:0]       status_c;
  logic                      hit_c;

  logic [FILL_W-1:0]         fill_r, fill_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r;
  logic                      out_hit_r;
  logic [COUNT_W-1:0]        out_count_r;

  // handshake
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = cell_used[CAPACITY-1];
  assign found    = prefix[CAPACITY];
  assign prefix[0] = 1'b0;

  // decode the word into cell control and result
  always_comb begin
    ctl          = '0;
    ctl.key      = in_value;
    status_c     = ST_DONE;
    hit_c        = 1'b0;
    fill_nxt     = fill_r;
    case (in_func)
      FN_INS_FRONT, FN_INS_BACK: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          ctl.shift_in = accept && (in_func == FN_INS_FRONT);
          ctl.append   = accept && (in_func == FN_INS_BACK);
          if (accept) begin
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
      end
      FN_DELETE, FN_SEARCH: begin
        if (!found) begin
          status_c = ST_MISS;
        end else begin
          hit_c = 1'b1;
          if (in_func == FN_DELETE) begin
            ctl.remove = accept;
            if (accept) begin
              fill_nxt = fill_r - FILL_W'(1);
            end
          end
        end
      end
      default: begin
        status_c = ST_MISS;
      end
    endcase
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lv, rv;
    logic                      lu, ru;
    if (i == 0) begin : g_first
      assign lv = in_value;
      assign lu = 1'b1;
    end else begin : g_mid_l
      assign lv = cell_value[i-1];
      assign lu = cell_used[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv = '0;
      assign ru = 1'b0;
    end else begin : g_mid_r
      assign rv = cell_value[i+1];
      assign ru = cell_used[i+1];
    end
    bole_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_value  (lv),
      .left_used   (lu),
      .right_value (rv),
      .right_used  (ru),
      .prefix_in   (prefix[i]),
      .value_o     (cell_value[i]),
      .used_o      (cell_used[i]),
      .prefix_out  (prefix[i+1])
    );
  end

  // result word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_c;
      out_hit_r    <= hit_c;
      out_count_r  <= COUNT_W'(fill_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hit         = out_hit_r;
  assign out_count_after = out_count_r;

  // occupied cells stay counted by the fill register
  assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_used) == int'(fill_r))
    else $error("cell occupancy disagrees with fill count");

  // occupied cells are packed at the front
  assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_used + 1'b1) & cell_used) == '0)
    else $error("occupied cells not packed at front");

  // a hit is only ever reported with done status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> out_status_r == ST_DONE)
    else $error("hit reported with non-done status");

  // an accepted delete that matches shrinks the list by one
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_func == FN_DELETE) && found |=> fill_r == $past(fill_r) - FILL_W'(1))
    else $error("delete hit did not shrink list");

  // an insert into a full store leaves the count alone and reports full
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && full && ((in_func == FN_INS_FRONT) || (in_func == FN_INS_BACK))
    |=> (out_status_r == ST_FULL) && $stable(fill_r))
    else $error("full insert not refused");

endmodule

// ===== verif/tb_bounded_ordered_list_engine_top.sv =====
// testbench for the bounded ordered list engine: directed corners, random traffic, scoreboard
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine_top;
  import bole_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 5;
  localparam int IDLE_PCT = 27;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  // one expected result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [COUNT_W-1:0]  count_after;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [FUNC_W-1:0]         in_func;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic                      out_hit;
  logic [COUNT_W-1:0]        out_count_after;

  // shadow copy of the stored list, front at index 0
  logic signed [VALUE_W-1:0] shadow_list[$];
  // results still owed by the block, oldest first
  list_result_t              pending_results[$];

  int errors = 0;
  int cycle_cnt = 0;
  bit idle_on = 1'b1;
  bit grow_bias = 1'b1;

  bounded_ordered_list_engine_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_count_after (out_count_after)
  );

  always #HALF_PERIOD clk = ~clk;

  // apply one operation to the shadow list and return the result it owes
  function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] fn,
                                                 input logic signed [VALUE_W-1:0] v);
    list_result_t r;
    int pos;
    int i;
    r.status = ST_DONE;
    r.hit = 1'b0;
    pos = -1;
    if (fn == FN_INS_FRONT || fn == FN_INS_BACK) begin
      if (shadow_list.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else if (fn == FN_INS_FRONT) begin
        shadow_list.push_front(v);
      end else begin
        shadow_list.push_back(v);
      end
    end else begin
      // first match counted from the front
      for (i = 0; i < shadow_list.size(); i++) begin
        if (pos < 0 && shadow_list[i] === v) pos = i;
      end
      if (pos < 0) begin
        r.status = ST_MISS;
      end else begin
        r.hit = 1'b1;
        if (fn == FN_DELETE) shadow_list.delete(pos);
      end
    end
    r.count_after = COUNT_W'(shadow_list.size());
    return r;
  endfunction

  // value source: stored entries, a small pool with duplicates, extremes, or anything
  function automatic logic signed [VALUE_W-1:0] pick_value(input bit from_list);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (from_list && shadow_list.size() > 0 && r < 50)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    r = $urandom_range(0, 99);
    k = int'($urandom_range(0, 6)) - 3;
    if (r < 35) return k;
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(VALUE_W-1){1'b0}}};
        1: return {1'b0, {(VALUE_W-1){1'b1}}};
        2: return {VALUE_W{1'b1}};
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // send one word, with random gaps ahead of it, and log its expected result
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic signed [VALUE_W-1:0] v);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= fn;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_list_op(fn, v));
  endtask

  // empty store, extreme values, full store, duplicates, near misses
  task automatic test_directed_corners();
    int k;
    send_word(FN_SEARCH, '0);
    send_word(FN_DELETE, {VALUE_W{1'b1}});
    send_word(FN_INS_BACK, {1'b0, {(VALUE_W-1){1'b1}}});
    send_word(FN_INS_FRONT, {1'b1, {(VALUE_W-1){1'b0}}});
    send_word(FN_INS_BACK, '0);
    send_word(FN_INS_FRONT, {VALUE_W{1'b1}});
    send_word(FN_SEARCH, {1'b1, {(VALUE_W-1){1'b0}}});
    // one bit away from a stored value
    send_word(FN_SEARCH, {1'b0, {(VALUE_W-2){1'b1}}, 1'b0});
    // delete the entry at the back
    send_word(FN_DELETE, '0);
    // fill up, with duplicates and alternating bit patterns
    for (k = 0; shadow_list.size() < CAPACITY; k++) begin
      send_word(k[0] ? FN_INS_BACK : FN_INS_FRONT,
                (k % 3 == 0) ? 32'sd5 : (k[1] ? 32'sh5555_5555 : 32'shaaaa_aaaa));
    end
    send_word(FN_INS_FRONT, 32'sd7);
    send_word(FN_INS_BACK, 32'sd7);
    send_word(FN_SEARCH, {1'b0, {(VALUE_W-1){1'b1}}});
    // first of several equal entries goes
    send_word(FN_DELETE, 32'sd5);
    send_word(FN_DELETE, {VALUE_W{1'b1}});
    send_word(FN_DELETE, 32'sd12345);
  endtask

  // random operations that swing between filling and draining the store
  task automatic run_random_words(input int n_words);
    logic [FUNC_W-1:0] fn;
    int r;
    repeat (n_words) begin
      if (shadow_list.size() >= CAPACITY) grow_bias = 1'b0;
      else if (shadow_list.size() == 0) grow_bias = 1'b1;
      else if ($urandom_range(0, 99) < 3) grow_bias = !grow_bias;
      r = $urandom_range(0, 99);
      if (grow_bias)
        fn = (r < 35) ? FN_INS_FRONT : (r < 65) ? FN_INS_BACK : (r < 85) ? FN_DELETE : FN_SEARCH;
      else
        fn = (r < 12) ? FN_INS_FRONT : (r < 24) ? FN_INS_BACK : (r < 70) ? FN_DELETE : FN_SEARCH;
      send_word(fn, pick_value(fn == FN_DELETE || fn == FN_SEARCH));
    end
  endtask

  task automatic test_random_with_stalls(input int n_words);
    idle_on = 1'b1;
    run_random_words(n_words);
  endtask

  // full rate on both sides
  task automatic test_back_to_back(input int n_words);
    idle_on = 1'b0;
    run_random_words(n_words);
    idle_on = 1'b1;
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
          errors++;
        end
        if (out_hit !== want.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", want.hit, out_hit);
          errors++;
        end
        if (out_count_after !== want.count_after) begin
          $error("count_after mismatch: expected %0d, actual %0d",
                 want.count_after, out_count_after);
          errors++;
        end
      end
    end
    out_ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // reset, tests in turn, drain, verdict
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_func   <= FN_INS_FRONT;
    in_value  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_with_stalls(420);
    test_back_to_back(230);
    test_random_with_stalls(400);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
